/* sv/ubxp_pkg.sv */
// ----------------------------------------------------------------------------
// ubxp_pkg
// shared types and constants for the nav pvt frame parser
// ----------------------------------------------------------------------------
package ubxp_pkg;

   // frame phase codes
   localparam logic [3:0] PH_SYNC1   = 4'd0;
   localparam logic [3:0] PH_SYNC2   = 4'd1;
   localparam logic [3:0] PH_CLASS   = 4'd2;
   localparam logic [3:0] PH_IDENT   = 4'd3;
   localparam logic [3:0] PH_LEN_LO  = 4'd4;
   localparam logic [3:0] PH_LEN_HI  = 4'd5;
   localparam logic [3:0] PH_PAYLOAD = 4'd6;
   localparam logic [3:0] PH_CK_A    = 4'd7;
   localparam logic [3:0] PH_CK_B    = 4'd8;

   localparam logic [7:0]  SYNC1_BYTE   = 8'hB5;
   localparam logic [7:0]  SYNC2_BYTE   = 8'h62;
   localparam logic [7:0]  NAV_CLASS    = 8'h01;
   localparam logic [7:0]  PVT_IDENT    = 8'h07;
   localparam logic [15:0] PVT_MIN_LEN  = 16'd40;

   // floor(t / 1000) = (t * DIV_MULT) >> DIV_SHIFT for any 32-bit t
   localparam logic [31:0] DIV_MULT     = 32'd2199023256;
   localparam int          DIV_SHIFT    = 41;
   localparam int          FIX_TIME_W   = 23;
   localparam logic [FIX_TIME_W-1:0] FIX_TIME_MAX = 23'd4294967;

   typedef struct packed {
      logic [31:0]        tow_ms;
      logic [15:0]        week_number;
      logic [7:0]         fix_kind;
      logic               fix_ok;
      logic signed [31:0] lon_e7;
      logic signed [31:0] lat_e7;
      logic signed [31:0] altitude_mm;
   } pvt_fields_type;

   typedef struct packed {
      logic       emit;
      logic [3:0] phase;
   } fsm_status_type;

endpackage

/* sv/ubxp_div1000.sv */
// ----------------------------------------------------------------------------
// ubxp_div1000
// microsecond to millisecond conversion by reciprocal multiplication
// ----------------------------------------------------------------------------
module ubxp_div1000 (
   input  logic [31:0]                      time_us,
   output logic [ubxp_pkg::FIX_TIME_W-1:0]  time_ms
);

   logic [63:0] product;

   assign product = {32'd0, time_us} * {32'd0, ubxp_pkg::DIV_MULT};
   assign time_ms = product[ubxp_pkg::DIV_SHIFT +: ubxp_pkg::FIX_TIME_W];

endmodule

/* sv/ubxp_frame_fsm.sv */
// ----------------------------------------------------------------------------
// ubxp_frame_fsm
// byte-wide frame sync, fletcher checksum and pvt field capture
// ----------------------------------------------------------------------------
module ubxp_frame_fsm #(
   parameter int MAX_PAYLOAD = 128
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic [7:0]                      rx_byte,
   output ubxp_pkg::fsm_status_type        status,
   output ubxp_pkg::pvt_fields_type        fields
);

   logic [3:0]  phase_ff,   phase_in;
   logic [7:0]  class_ff,   class_in;
   logic [7:0]  ident_ff,   ident_in;
   logic [15:0] length_ff,  length_in;
   logic [7:0]  count_ff,   count_in;
   logic [7:0]  sum_a_ff,   sum_a_in;
   logic [7:0]  sum_b_ff,   sum_b_in;
   logic [7:0]  rx_sum_a_ff, rx_sum_a_in;
   logic [7:0]  run_a, run_b;
   logic [7:0]  count_next;
   logic [15:0] full_length;
   logic        emit;

   ubxp_pkg::pvt_fields_type fields_ff, fields_in;

   assign run_a       = sum_a_ff + rx_byte;
   assign run_b       = sum_b_ff + run_a;
   assign count_next  = count_ff + 8'd1;
   assign full_length = {rx_byte, length_ff[7:0]};

   always_comb begin
      phase_in    = phase_ff;
      class_in    = class_ff;
      ident_in    = ident_ff;
      length_in   = length_ff;
      count_in    = count_ff;
      sum_a_in    = sum_a_ff;
      sum_b_in    = sum_b_ff;
      rx_sum_a_in = rx_sum_a_ff;
      fields_in   = fields_ff;
      emit        = 1'b0;
      unique case (phase_ff)
         ubxp_pkg::PH_SYNC1: begin
            if (rx_byte == ubxp_pkg::SYNC1_BYTE) phase_in = ubxp_pkg::PH_SYNC2;
         end
         ubxp_pkg::PH_SYNC2: begin
            if (rx_byte == ubxp_pkg::SYNC2_BYTE) begin
               phase_in = ubxp_pkg::PH_CLASS;
               sum_a_in = 8'd0;
               sum_b_in = 8'd0;
            end else begin
               phase_in = ubxp_pkg::PH_SYNC1;
            end
         end
         ubxp_pkg::PH_CLASS: begin
            class_in = rx_byte;
            sum_a_in = run_a;
            sum_b_in = run_b;
            phase_in = ubxp_pkg::PH_IDENT;
         end
         ubxp_pkg::PH_IDENT: begin
            ident_in = rx_byte;
            sum_a_in = run_a;
            sum_b_in = run_b;
            phase_in = ubxp_pkg::PH_LEN_LO;
         end
         ubxp_pkg::PH_LEN_LO: begin
            length_in = {8'd0, rx_byte};
            sum_a_in  = run_a;
            sum_b_in  = run_b;
            phase_in  = ubxp_pkg::PH_LEN_HI;
         end
         ubxp_pkg::PH_LEN_HI: begin
            length_in = full_length;
            sum_a_in  = run_a;
            sum_b_in  = run_b;
            count_in  = 8'd0;
            if (full_length > 16'(MAX_PAYLOAD)) phase_in = ubxp_pkg::PH_SYNC1;
            else if (full_length == 16'd0)      phase_in = ubxp_pkg::PH_CK_A;
            else                                phase_in = ubxp_pkg::PH_PAYLOAD;
         end
         ubxp_pkg::PH_PAYLOAD: begin
            count_in = count_next;
            sum_a_in = run_a;
            sum_b_in = run_b;
            if ({8'd0, count_next} >= length_ff) phase_in = ubxp_pkg::PH_CK_A;
            // only the bytes that feed a result field are kept
            unique case (count_ff)
               8'd0:  fields_in.tow_ms[7:0]        = rx_byte;
               8'd1:  fields_in.tow_ms[15:8]       = rx_byte;
               8'd2:  fields_in.tow_ms[23:16]      = rx_byte;
               8'd3:  fields_in.tow_ms[31:24]      = rx_byte;
               8'd8:  fields_in.week_number[7:0]   = rx_byte;
               8'd9:  fields_in.week_number[15:8]  = rx_byte;
               8'd20: fields_in.fix_kind           = rx_byte;
               8'd21: fields_in.fix_ok             = rx_byte[0];
               8'd24: fields_in.lon_e7[7:0]        = rx_byte;
               8'd25: fields_in.lon_e7[15:8]       = rx_byte;
               8'd26: fields_in.lon_e7[23:16]      = rx_byte;
               8'd27: fields_in.lon_e7[31:24]      = rx_byte;
               8'd28: fields_in.lat_e7[7:0]        = rx_byte;
               8'd29: fields_in.lat_e7[15:8]       = rx_byte;
               8'd30: fields_in.lat_e7[23:16]      = rx_byte;
               8'd31: fields_in.lat_e7[31:24]      = rx_byte;
               8'd32: fields_in.altitude_mm[7:0]   = rx_byte;
               8'd33: fields_in.altitude_mm[15:8]  = rx_byte;
               8'd34: fields_in.altitude_mm[23:16] = rx_byte;
               8'd35: fields_in.altitude_mm[31:24] = rx_byte;
               default: ;
            endcase
         end
         ubxp_pkg::PH_CK_A: begin
            rx_sum_a_in = rx_byte;
            phase_in    = ubxp_pkg::PH_CK_B;
         end
         ubxp_pkg::PH_CK_B: begin
            emit     = (rx_sum_a_ff == sum_a_ff) && (rx_byte == sum_b_ff) &&
                       (class_ff == ubxp_pkg::NAV_CLASS) &&
                       (ident_ff == ubxp_pkg::PVT_IDENT) &&
                       (length_ff >= ubxp_pkg::PVT_MIN_LEN);
            phase_in = ubxp_pkg::PH_SYNC1;
         end
         default: begin
            phase_in = ubxp_pkg::PH_SYNC1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= ubxp_pkg::PH_SYNC1;
         class_ff    <= 8'd0;
         ident_ff    <= 8'd0;
         length_ff   <= 16'd0;
         count_ff    <= 8'd0;
         sum_a_ff    <= 8'd0;
         sum_b_ff    <= 8'd0;
         rx_sum_a_ff <= 8'd0;
      end else if (step) begin
         phase_ff    <= phase_in;
         class_ff    <= class_in;
         ident_ff    <= ident_in;
         length_ff   <= length_in;
         count_ff    <= count_in;
         sum_a_ff    <= sum_a_in;
         sum_b_ff    <= sum_b_in;
         rx_sum_a_ff <= rx_sum_a_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         fields_ff <= fields_in;
      end
   end

   assign status.emit  = emit;
   assign status.phase = phase_ff;
   assign fields       = fields_ff;

endmodule

/* sv/ubx_frame_parser_pvt_extract.sv */
// ----------------------------------------------------------------------------
// ubx_frame_parser_pvt_extract
// nav pvt frame parser: serial bytes in, decoded position records out
// ----------------------------------------------------------------------------
// usage
//   request channel req_*: one received byte with its microsecond arrival time
//   per request. response channel rsp_*: one decoded pvt record, produced only
//   on the second checksum byte of a good nav pvt frame; other bytes give none.
//   a request passes an input register, then the frame machine updates on it
//   while the result register loads the record of the frame that the request
//   completes. throughput is one request per cycle while the receiver does
//   not stall a held record, set by the single byte-wide state step of the
//   frame machine; the divide by 1000 is one 32x32 multiply in the same step.
//   reset returns the machine to hunting the first sync byte and empties both
//   registers. while the receiver stalls a held record, one more request is
//   taken into the input register, then req_tready drops until the record
//   is taken.
// ----------------------------------------------------------------------------
module ubx_frame_parser_pvt_extract #(
   parameter int MAX_PAYLOAD = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [39:0]  req_tdata,   // rx_byte, time_us
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [175:0] rsp_tdata    // tow_ms, week_number, fix_kind, fix_ok,
                                     // lon_e7, lat_e7, altitude_mm, fix_time_ms
);

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic [31:0] in_time_ff;
   logic        advance;
   logic        load_rsp;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [175:0] rsp_data_ff;
   logic [ubxp_pkg::FIX_TIME_W-1:0] time_ms;

   ubxp_pkg::fsm_status_type status;
   ubxp_pkg::pvt_fields_type fields;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign load_rsp   = advance && status.emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata[7:0];
         in_time_ff <= req_tdata[39:8];
      end
   end

   ubxp_frame_fsm #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_fsm (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .status  (status),
      .fields  (fields)
   );

   ubxp_div1000 u_div (
      .time_us (in_time_ff),
      .time_ms (time_ms)
   );

   assign rsp_valid_in = advance ? status.emit : (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload bytes of the current frame are final once the second checksum arrives
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff <= {time_ms, fields.altitude_mm, fields.lat_e7, fields.lon_e7,
                         fields.fix_ok, fields.fix_kind, fields.week_number,
                         fields.tow_ms};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_emit_on_second_checksum: assert property (@(posedge clock) disable iff (reset)
      status.emit |-> (status.phase == ubxp_pkg::PH_CK_B))
      else $error("record raised outside the second checksum byte");

   a_load_shows_record: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> rsp_tvalid)
      else $error("loaded record not presented");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("request side stalled without a held record");

   a_fix_time_range: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> (rsp_data_ff[175:153] <= ubxp_pkg::FIX_TIME_MAX))
      else $error("millisecond time out of range");

endmodule

/* tb/sv/ubx_frame_parser_pvt_extract_test.sv */
// ----------------------------------------------------------------------------
// ubx_frame_parser_pvt_extract_test
// self-checking bench for the nav pvt frame parser. serial bytes are sent as
// requests, a frame model of its own predicts each decoded record, and every
// record that leaves the block is compared field by field with the oldest
// prediction. directed frames cover the special cases, then random frames
// (mostly good ones) run with idling on both sides, a long output hold-off
// and a full-rate stretch at the end.
// ----------------------------------------------------------------------------
module ubx_frame_parser_pvt_extract_test;

   localparam int MAX_PAYLOAD     = 128;
   localparam int HEAD_BYTES      = 36;
   localparam int CYCLE_LIMIT     = 500000;
   localparam int RANDOM_REQUESTS = 1100;
   localparam int RANDOM_RECORDS  = 60;
   localparam int REPORT_LIMIT    = 10;
   localparam int HOLD_OFF_CYCLES = 400;

   typedef enum logic [1:0] {CK_INTACT, CK_BREAK_A, CK_BREAK_B} ck_mode_type;

   // same layout as rsp_tdata, tow_ms in the lowest bits
   typedef struct packed {
      logic [22:0]        fix_time_ms;
      logic signed [31:0] altitude_mm;
      logic signed [31:0] lat_e7;
      logic signed [31:0] lon_e7;
      logic               fix_ok;
      logic [7:0]         fix_kind;
      logic [15:0]        week_number;
      logic [31:0]        tow_ms;
   } pvt_record_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [39:0]  req_tdata  = '0;   // rx_byte, time_us
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [175:0] rsp_tdata;         // tow_ms, week_number, fix_kind, fix_ok,
                                    // lon_e7, lat_e7, altitude_mm, fix_time_ms

   // frame model state
   logic [3:0]  fm_phase    = ubxp_pkg::PH_SYNC1;
   logic [7:0]  fm_class    = '0;
   logic [7:0]  fm_ident    = '0;
   logic [15:0] fm_length   = '0;
   logic [7:0]  fm_count    = '0;
   logic [7:0]  fm_sum_a    = '0;
   logic [7:0]  fm_sum_b    = '0;
   logic [7:0]  fm_rx_sum_a = '0;
   logic [7:0]  fm_head [HEAD_BYTES];

   pvt_record_type pending_records[$];
   pvt_record_type seen_record;
   pvt_record_type want_record;
   logic [7:0]  payload_buf [256];
   int          records_expected = 0;
   int          bytes_sent       = 0;
   int          mismatches       = 0;
   int          cycle_count      = 0;
   int          hold_left        = 0;
   int          stall_left       = 0;
   bit          idle_on          = 1'b0;
   bit          stall_on         = 1'b0;

   ubx_frame_parser_pvt_extract #(.MAX_PAYLOAD(MAX_PAYLOAD)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial forever #6 clock = ~clock;

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[ubx_frame_parser_pvt_extract] ERROR");
      $finish;
   end

   // ---------------------------------------------------------------- model

   task automatic add_to_checksum(input logic [7:0] b);
      fm_sum_a = fm_sum_a + b;
      fm_sum_b = fm_sum_b + fm_sum_a;
   endtask

   task automatic step_frame_machine(input logic [7:0] b, input logic [31:0] stamp_us);
      pvt_record_type rec;
      logic [31:0] quotient;
      unique case (fm_phase)
         ubxp_pkg::PH_SYNC1: begin
            if (b == ubxp_pkg::SYNC1_BYTE) fm_phase = ubxp_pkg::PH_SYNC2;
         end
         ubxp_pkg::PH_SYNC2: begin
            if (b == ubxp_pkg::SYNC2_BYTE) begin
               fm_phase = ubxp_pkg::PH_CLASS;
               fm_sum_a = '0;
               fm_sum_b = '0;
            end else begin
               fm_phase = ubxp_pkg::PH_SYNC1;
            end
         end
         ubxp_pkg::PH_CLASS: begin
            fm_class = b;
            add_to_checksum(b);
            fm_phase = ubxp_pkg::PH_IDENT;
         end
         ubxp_pkg::PH_IDENT: begin
            fm_ident = b;
            add_to_checksum(b);
            fm_phase = ubxp_pkg::PH_LEN_LO;
         end
         ubxp_pkg::PH_LEN_LO: begin
            fm_length = {8'd0, b};
            add_to_checksum(b);
            fm_phase = ubxp_pkg::PH_LEN_HI;
         end
         ubxp_pkg::PH_LEN_HI: begin
            fm_length[15:8] = b;
            add_to_checksum(b);
            fm_count = '0;
            if (fm_length > 16'(MAX_PAYLOAD)) fm_phase = ubxp_pkg::PH_SYNC1;
            else if (fm_length == 16'd0) fm_phase = ubxp_pkg::PH_CK_A;
            else fm_phase = ubxp_pkg::PH_PAYLOAD;
         end
         ubxp_pkg::PH_PAYLOAD: begin
            if (fm_count < 8'(HEAD_BYTES)) fm_head[fm_count[5:0]] = b;
            fm_count = fm_count + 8'd1;
            add_to_checksum(b);
            if ({8'd0, fm_count} >= fm_length) fm_phase = ubxp_pkg::PH_CK_A;
         end
         ubxp_pkg::PH_CK_A: begin
            fm_rx_sum_a = b;
            fm_phase = ubxp_pkg::PH_CK_B;
         end
         ubxp_pkg::PH_CK_B: begin
            if (fm_rx_sum_a == fm_sum_a && b == fm_sum_b &&
                fm_class == ubxp_pkg::NAV_CLASS && fm_ident == ubxp_pkg::PVT_IDENT &&
                fm_length >= ubxp_pkg::PVT_MIN_LEN) begin
               quotient        = stamp_us / 32'd1000;
               rec.tow_ms      = {fm_head[3], fm_head[2], fm_head[1], fm_head[0]};
               rec.week_number = {fm_head[9], fm_head[8]};
               rec.fix_kind    = fm_head[20];
               rec.fix_ok      = fm_head[21][0];
               rec.lon_e7      = {fm_head[27], fm_head[26], fm_head[25], fm_head[24]};
               rec.lat_e7      = {fm_head[31], fm_head[30], fm_head[29], fm_head[28]};
               rec.altitude_mm = {fm_head[35], fm_head[34], fm_head[33], fm_head[32]};
               rec.fix_time_ms = quotient[ubxp_pkg::FIX_TIME_W-1:0];
               pending_records.push_back(rec);
               records_expected++;
            end
            fm_phase = ubxp_pkg::PH_SYNC1;
         end
         default: fm_phase = ubxp_pkg::PH_SYNC1;
      endcase
   endtask

   // ---------------------------------------------------------------- checking

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("mismatch in %s: expected %h, got %h", what, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         seen_record = rsp_tdata;
         if (pending_records.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected record: expected none, got %h", rsp_tdata);
         end else begin
            want_record = pending_records.pop_front();
            check_field("tow_ms", want_record.tow_ms, seen_record.tow_ms);
            check_field("week_number", 32'(want_record.week_number),
                        32'(seen_record.week_number));
            check_field("fix_kind", 32'(want_record.fix_kind),
                        32'(seen_record.fix_kind));
            check_field("fix_ok", 32'(want_record.fix_ok), 32'(seen_record.fix_ok));
            check_field("lon_e7", want_record.lon_e7, seen_record.lon_e7);
            check_field("lat_e7", want_record.lat_e7, seen_record.lat_e7);
            check_field("altitude_mm", want_record.altitude_mm, seen_record.altitude_mm);
            check_field("fix_time_ms", 32'(want_record.fix_time_ms),
                        32'(seen_record.fix_time_ms));
         end
      end
   end

   // receiver: a long hold-off takes precedence over random stall bursts
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (stall_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 9) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic send_req(input logic [7:0] rx_byte, input logic [31:0] stamp_us);
      int gap;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 9);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {stamp_us, rx_byte};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      step_frame_machine(rx_byte, stamp_us);
   endtask

   task automatic fill_payload(input logic [7:0] value, input bit randomise);
      for (int i = 0; i < 256; i++)
         payload_buf[i] = randomise ? 8'($urandom_range(0, 255)) : value;
   endtask

   // sync, header, payload from payload_buf, checksum; oversize stops after length
   task automatic send_frame(input logic [7:0] cls, input logic [7:0] ident,
                             input logic [15:0] len, input ck_mode_type ck_mode,
                             input logic [31:0] ck_stamp);
      logic [7:0]  ck_a;
      logic [7:0]  ck_b;
      logic [7:0]  flip;
      logic [31:0] header;
      ck_a   = '0;
      ck_b   = '0;
      header = {len[15:8], len[7:0], ident, cls};
      send_req(ubxp_pkg::SYNC1_BYTE, $urandom());
      send_req(ubxp_pkg::SYNC2_BYTE, $urandom());
      for (int i = 0; i < 4; i++) begin
         ck_a = ck_a + header[8*i +: 8];
         ck_b = ck_b + ck_a;
         send_req(header[8*i +: 8], $urandom());
      end
      if (len <= 16'(MAX_PAYLOAD)) begin
         for (int i = 0; i < len; i++) begin
            ck_a = ck_a + payload_buf[i];
            ck_b = ck_b + ck_a;
            send_req(payload_buf[i], $urandom());
         end
         flip = 8'($urandom_range(1, 255));
         if (ck_mode == CK_BREAK_A) ck_a = ck_a ^ flip;
         if (ck_mode == CK_BREAK_B) ck_b = ck_b ^ flip;
         send_req(ck_a, $urandom());
         send_req(ck_b, ck_stamp);
      end
   endtask

   task automatic send_random_frame();
      int          pick;
      logic [15:0] len;
      logic [7:0]  cls;
      logic [7:0]  ident;
      logic [7:0]  stray;
      pick  = $urandom_range(0, 99);
      len   = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(40, MAX_PAYLOAD))
                                          : 16'($urandom_range(40, 44));
      cls   = $urandom_range(0, 1) ? ubxp_pkg::NAV_CLASS : 8'($urandom_range(0, 255));
      ident = $urandom_range(0, 1) ? ubxp_pkg::PVT_IDENT : 8'($urandom_range(0, 255));
      fill_payload(8'd0, 1'b1);
      if (pick < 70) begin
         send_frame(ubxp_pkg::NAV_CLASS, ubxp_pkg::PVT_IDENT, len, CK_INTACT, $urandom());
      end else if (pick < 75) begin
         send_frame(ubxp_pkg::NAV_CLASS, ubxp_pkg::PVT_IDENT, len, CK_BREAK_A, $urandom());
      end else if (pick < 80) begin
         send_frame(ubxp_pkg::NAV_CLASS, ubxp_pkg::PVT_IDENT, len, CK_BREAK_B, $urandom());
      end else if (pick < 85) begin
         send_frame(cls, ident, len, CK_INTACT, $urandom());
      end else if (pick < 89) begin
         send_frame(ubxp_pkg::NAV_CLASS, ubxp_pkg::PVT_IDENT, 16'($urandom_range(0, 39)),
                    CK_INTACT, $urandom());
      end else if (pick < 92) begin
         send_frame(ubxp_pkg::NAV_CLASS, ubxp_pkg::PVT_IDENT,
                    16'($urandom_range(MAX_PAYLOAD + 1, 65535)), CK_INTACT, $urandom());
      end else if (pick < 96) begin
         repeat ($urandom_range(1, 8)) send_req(8'($urandom_range(0, 255)), $urandom());
      end else begin
         stray = 8'($urandom_range(0, 255));
         if (stray == ubxp_pkg::SYNC2_BYTE) stray = ubxp_pkg::SYNC1_BYTE;
         send_req(ubxp_pkg::SYNC1_BYTE, $urandom());
         send_req(stray, $urandom());
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed_frames();
      idle_on  = 1'b1;
      stall_on = 1'b1;
      fill_payload(8'h00, 1'b0);
      send_frame(ubxp_pkg::NAV_CLASS, ubxp_pkg::PVT_IDENT, 16'd40, CK_INTACT,
                 32'h0000_0000);
      fill_payload(8'hFF, 1'b0);
      send_frame(ubxp_pkg::NAV_CLASS, ubxp_pkg::PVT_IDENT, 16'd40, CK_INTACT,
                 32'hFFFF_FFFF);
      fill_payload(8'd0, 1'b1);
      payload_buf[21] = 8'hFE;
      send_frame(ubxp_pkg::NAV_CLASS, ubxp_pkg::PVT_IDENT, 16'd92, CK_INTACT, 32'd999);
      fill_payload(8'd0, 1'b1);
      payload_buf[21] = 8'h01;
      send_frame(ubxp_pkg::NAV_CLASS, ubxp_pkg::PVT_IDENT, 16'(MAX_PAYLOAD), CK_INTACT,
                 32'd1000);
      // most negative longitude, most positive latitude, height zero
      fill_payload(8'd0, 1'b1);
      {payload_buf[27], payload_buf[26], payload_buf[25], payload_buf[24]} = 32'h8000_0000;
      {payload_buf[31], payload_buf[30], payload_buf[29], payload_buf[28]} = 32'h7FFF_FFFF;
      {payload_buf[35], payload_buf[34], payload_buf[33], payload_buf[32]} = 32'h0000_0000;
      send_frame(ubxp_pkg::NAV_CLASS, ubxp_pkg::PVT_IDENT, 16'd40, CK_INTACT,
                 32'd4_294_966_999);
      // frames that give no record
      fill_payload(8'd0, 1'b1);
      send_frame(ubxp_pkg::NAV_CLASS, ubxp_pkg::PVT_IDENT, 16'd39, CK_INTACT, $urandom());
      send_frame(ubxp_pkg::NAV_CLASS, ubxp_pkg::PVT_IDENT, 16'd40, CK_BREAK_A, $urandom());
      send_frame(ubxp_pkg::NAV_CLASS, ubxp_pkg::PVT_IDENT, 16'd40, CK_BREAK_B, $urandom());
      send_frame(8'h02, ubxp_pkg::PVT_IDENT, 16'd40, CK_INTACT, $urandom());
      send_frame(ubxp_pkg::NAV_CLASS, 8'h06, 16'd40, CK_INTACT, $urandom());
      send_frame(ubxp_pkg::NAV_CLASS, ubxp_pkg::PVT_IDENT, 16'd0, CK_INTACT, $urandom());
      send_frame(ubxp_pkg::NAV_CLASS, ubxp_pkg::PVT_IDENT, 16'(MAX_PAYLOAD + 1),
                 CK_INTACT, $urandom());
      send_frame(ubxp_pkg::NAV_CLASS, ubxp_pkg::PVT_IDENT, 16'h0100, CK_INTACT,
                 $urandom());
      send_frame(ubxp_pkg::NAV_CLASS, ubxp_pkg::PVT_IDENT, 16'hFFFF, CK_INTACT,
                 $urandom());
      // repeated first sync drops back to hunting, then a stray second sync
      send_req(ubxp_pkg::SYNC1_BYTE, $urandom());
      send_req(ubxp_pkg::SYNC1_BYTE, $urandom());
      send_req(ubxp_pkg::SYNC2_BYTE, $urandom());
      send_frame(ubxp_pkg::NAV_CLASS, ubxp_pkg::PVT_IDENT, 16'd40, CK_INTACT, $urandom());
      send_req(ubxp_pkg::SYNC1_BYTE, $urandom());
      send_req(8'h00, $urandom());
      send_frame(ubxp_pkg::NAV_CLASS, ubxp_pkg::PVT_IDENT, 16'd41, CK_INTACT, $urandom());
   endtask

   task automatic test_random_frames();
      while (bytes_sent < RANDOM_REQUESTS || records_expected < RANDOM_RECORDS) begin
         idle_on  = ($urandom_range(0, 3) != 0);
         stall_on = ($urandom_range(0, 3) != 0);
         send_random_frame();
      end
   endtask

   // records pile up while the receiver holds off, so the request side stalls
   task automatic test_output_hold_off();
      idle_on   = 1'b0;
      stall_on  = 1'b0;
      hold_left = HOLD_OFF_CYCLES;
      repeat (4) begin
         fill_payload(8'd0, 1'b1);
         send_frame(ubxp_pkg::NAV_CLASS, ubxp_pkg::PVT_IDENT, 16'd40, CK_INTACT,
                    $urandom());
      end
   endtask

   task automatic test_full_rate();
      idle_on  = 1'b0;
      stall_on = 1'b0;
      repeat (4) send_random_frame();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_frames();
      test_random_frames();
      test_output_hold_off();
      test_full_rate();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_records.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending_records.size() == 0) begin
         $display("[ubx_frame_parser_pvt_extract] OK");
      end else begin
         $display("[ubx_frame_parser_pvt_extract] ERROR");
      end
      $finish;
   end

endmodule
